[design/assert_macros.svh]
// Assertion macros used by the checker of the queue block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that stays armed through reset.
`define MPQ_ASSERT_NXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/mpq_pkg.sv]
// Shared constants, codes and types of the min priority queue.
`default_nettype none

package mpq_pkg;

    // Queue geometry
    localparam int CAPACITY = 128;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // Operation codes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_PEEK   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    // Control from the sequencer to the minimum tracker
    typedef struct packed {
        logic              clr;
        logic              vld;
        logic [ADDR_W-1:0] idx;
    } t_min_ctl;

    // Running minimum reported back to the sequencer
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [ADDR_W-1:0]        idx;
    } t_min_res;

endpackage

`default_nettype wire

[design/min_priority_queue_linear_scan_core.sv]
// Top level of the min priority queue: sequencer, entry memory and result register.
//
// Unsorted min priority queue of CAPACITY signed 32-bit entries held in one
// single-port-write, single-port-read memory with registered read data.
// Insert appends at the tail and goes straight to the done state. Peek
// scans all N stored entries through one shared compare unit, one memory
// read per cycle. Delete does the same scan and then moves every entry
// behind the minimum down one slot, one read and one write per cycle.
// The memory port is the limit: each entry visit costs one memory read.
// One transaction is in work at a time; o_in_stall is high from the cycle
// after acceptance until the result sits in the output register. A result
// waits there until taken, while the next transaction may already enter.
// No clearing pass is needed after reset: only slots below the occupancy
// count are ever read.
`default_nettype none

module min_priority_queue_linear_scan_core
    import mpq_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  [1:0]               i_mode,
    input  wire  signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_result_value
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [CNT_W-1:0]         r_occ, n_occ;
    logic [CNT_W-1:0]         r_ptr, n_ptr;
    logic                     r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0]        r_rd_idx, n_rd_idx;
    logic                     r_is_del, n_is_del;
    logic [1:0]               r_res_status, n_res_status;
    logic signed [DATA_W-1:0] r_res_value, n_res_value;
    logic                     r_out_valid, n_out_valid;
    logic [1:0]               r_out_status;
    logic signed [DATA_W-1:0] r_out_value;

    logic [DATA_W-1:0]        r_mem [CAPACITY];
    logic signed [DATA_W-1:0] r_rdata;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;

    logic                     in_acc;
    logic                     out_free;
    logic                     reading;
    t_min_ctl                 min_ctl;
    t_min_res                 min_res;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign reading  = (r_ptr < r_occ);
    assign mem_raddr = r_ptr[ADDR_W-1:0];

    // Shared minimum tracker
    assign min_ctl.clr = in_acc;
    assign min_ctl.vld = (r_state == S_SCAN) && r_rd_vld;
    assign min_ctl.idx = r_rd_idx;

    mpq_min_unit u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (min_ctl),
        .i_data  (r_rdata),
        .o_res   (min_res)
    );

    // Memory write port: tail append on insert, move-down during shift
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_occ[ADDR_W-1:0];
        mem_wdata = i_value;
        if (in_acc && (i_mode == MODE_INSERT) && (r_occ < CNT_W'(CAPACITY))) begin
            mem_we = 1'b1;
        end else if ((r_state == S_SHIFT) && r_rd_vld) begin
            mem_we    = 1'b1;
            mem_waddr = r_rd_idx - ADDR_W'(1);
            mem_wdata = r_rdata;
        end
    end

    // Entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_ptr        = r_ptr;
        n_rd_vld     = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_is_del     = r_is_del;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_out_valid  = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_is_del     = (i_mode == MODE_DELETE);
                    n_res_status = ST_OK;
                    n_res_value  = '0;
                    n_ptr        = '0;
                    n_state      = S_DONE;
                    if (i_mode == MODE_INSERT) begin
                        if (r_occ < CNT_W'(CAPACITY)) begin
                            n_occ = r_occ + CNT_W'(1);
                        end else begin
                            n_res_status = ST_FULL;
                        end
                    end else if ((i_mode == MODE_DELETE) || (i_mode == MODE_PEEK)) begin
                        if (r_occ == '0) begin
                            n_res_status = ST_EMPTY;
                            n_res_value  = EMPTY_VALUE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN, S_SHIFT: begin
                if (reading) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_ptr[ADDR_W-1:0];
                    n_ptr    = r_ptr + CNT_W'(1);
                end else if (!r_rd_vld) begin
                    // Pipeline drained: scan finished or gap closed
                    n_res_value = min_res.value;
                    if ((r_state == S_SCAN) && r_is_del) begin
                        n_state = S_SHIFT;
                        n_ptr   = CNT_W'(min_res.idx) + CNT_W'(1);
                    end else begin
                        if (r_state == S_SHIFT) begin
                            n_occ = r_occ - CNT_W'(1);
                        end
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_rd_idx     <= n_rd_idx;
        r_is_del     <= n_is_del;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        if ((r_state == S_DONE) && out_free) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_value = r_out_value;

endmodule

`default_nettype wire

[design/mpq_min_unit.sv]
// Shared compare unit: tracks the smallest entry seen during a scan.
`default_nettype none

module mpq_min_unit
    import mpq_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire t_min_ctl            i_ctl,
    input  wire signed [DATA_W-1:0]  i_data,
    output t_min_res                 o_res
);

    logic                     r_have;
    logic signed [DATA_W-1:0] r_best;
    logic [ADDR_W-1:0]        r_best_idx;
    logic                     take;

    // Strictly smaller wins, so the earliest entry is kept on ties
    assign take = i_ctl.vld && (!r_have || (i_data < r_best));

    // Tracker occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clr) begin
            r_have <= 1'b0;
        end else if (i_ctl.vld) begin
            r_have <= 1'b1;
        end
    end

    // Best value and its slot
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best     <= i_data;
            r_best_idx <= i_ctl.idx;
        end
    end

    assign o_res.value = r_best;
    assign o_res.idx   = r_best_idx;

endmodule

`default_nettype wire

[design/mpq_checker.sv]
// Port-level checker for the min priority queue, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module mpq_checker
    import mpq_pkg::*;
(
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_in_valid,
    input wire                      o_in_stall,
    input wire                      o_out_valid,
    input wire                      i_out_stall,
    input wire [1:0]                o_status,
    input wire signed [DATA_W-1:0]  o_result_value
);

    // Reset empties the output register
    `MPQ_ASSERT_NXT_ANY(a_rst_out, i_clk, !i_rst_n, !o_out_valid)

    // A stalled result holds
    `MPQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_status) && $stable(o_result_value))

    // Block is busy right after taking a transaction
    `MPQ_ASSERT_NXT(a_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // Empty status always carries all ones
    `MPQ_ASSERT_IMP(a_empty_val, i_clk, i_rst_n, o_out_valid && (o_status == ST_EMPTY),
        o_result_value == EMPTY_VALUE)

    // Full status carries zero
    `MPQ_ASSERT_IMP(a_full_val, i_clk, i_rst_n, o_out_valid && (o_status == ST_FULL),
        o_result_value == '0)

endmodule

bind min_priority_queue_linear_scan_core mpq_checker u_mpq_checker (.*);

`default_nettype wire
